// ===== src/ec2c_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and stage bundles for the epoch to calendar converter
package ec2c_pkg;

    localparam int unsigned EPOCH_W = 32;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MDAY_W  = 5;
    localparam int unsigned MON_W   = 4;
    localparam int unsigned YEAR_W  = 12;

    // hours left within one year, fits 366 * 24
    localparam int unsigned YHRS_W  = 14;
    // day of year, 0 .. 365 before the plus one
    localparam int unsigned DOY_W   = 9;

    // reciprocal of 60 with a shift of 37, exact over 32 bits
    localparam logic [31:0] C_RECIP_60   = 32'h8888_8889;
    localparam int unsigned C_SHIFT_60   = 37;
    // reciprocal of 1461 * 24 with a shift of 36, exact for hours below 2^21
    localparam logic [20:0] C_RECIP_QUAD = 21'd1959830;
    localparam int unsigned C_SHIFT_QUAD = 36;
    localparam logic [20:0] C_HOURS_QUAD = 21'(1461 * 24);
    // reciprocal of 3 with a shift of 11, exact for values below 2048
    localparam logic [9:0]  C_RECIP_3    = 10'd683;
    localparam int unsigned C_SHIFT_3    = 11;

    localparam logic [11:0] C_BASE_YEAR  = 12'd1970;
    localparam logic [15:0] C_HOURS_COMMON = 16'(365 * 24);
    localparam logic [15:0] C_HOURS_LEAP   = 16'(366 * 24);
    localparam logic [DOY_W-1:0] C_LEAP_DAY = 9'd60;

    // last day of year of each month but december, common year
    localparam logic [DOY_W-1:0] C_MONTH_END [11] = '{
        9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [DOY_W-1:0] C_MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [MON_W-1:0]  C_MON_FEB   = 4'd1;
    localparam logic [MDAY_W-1:0] C_MDAY_FEB29 = 5'd29;

    typedef struct packed {
        logic              valid;
        logic              leap;
        logic [YHRS_W-1:0] hours;
    } t_day_in;

    typedef struct packed {
        logic              valid;
        logic [HOUR_W-1:0] hour;
        logic [MDAY_W-1:0] mday;
        logic [MON_W-1:0]  mon;
    } t_day_out;

endpackage

// ===== src/ec2c_date.sv =====
`timescale 1ns / 1ps
// hours within the year to hour of day, month and day of month (three stages)
module ec2c_date (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ec2c_pkg::t_day_in  i_day,
    output ec2c_pkg::t_day_out o_day
);
    import ec2c_pkg::*;

    // stage a: hours / 24 as (hours >> 3) / 3
    logic              r_va;
    logic              r_leap_a;
    logic [YHRS_W-1:0] r_hrs_a;
    logic [20:0]       r_prod_a;
    logic [20:0]       n_prod_a;

    // stage b: hour and day of year
    logic              r_vb;
    logic              r_feb29_b;
    logic [HOUR_W-1:0] r_hour_b;
    logic [DOY_W-1:0]  r_doy_b;
    logic [DOY_W-1:0]  n_day0;
    logic [DOY_W-1:0]  n_day;
    logic [YHRS_W-1:0] n_hour_full;
    logic [DOY_W-1:0]  n_doy;
    logic              n_feb29;

    // stage c: month walk
    logic              r_vc;
    logic [HOUR_W-1:0] r_hour_c;
    logic [MDAY_W-1:0] r_mday_c;
    logic [MON_W-1:0]  r_mon_c;
    logic [MON_W-1:0]  n_mon;
    logic [MDAY_W-1:0] n_mday;
    logic [DOY_W-1:0]  n_mday_full;

    assign n_prod_a = 21'(i_day.hours[YHRS_W-1:3]) * 21'(C_RECIP_3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_day.valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_leap_a <= i_day.leap;
        r_hrs_a  <= i_day.hours;
        r_prod_a <= n_prod_a;
    end

    always_comb begin
        n_day0      = r_prod_a[C_SHIFT_3 +: DOY_W];
        n_hour_full = r_hrs_a - ({5'b0, n_day0} * YHRS_W'(24));
        n_day       = n_day0 + DOY_W'(1);
        n_feb29     = r_leap_a && (n_day == C_LEAP_DAY);
        // days after the leap day fall back onto the common-year table
        n_doy       = (r_leap_a && (n_day > C_LEAP_DAY)) ? n_day - DOY_W'(1) : n_day;
    end

    always_ff @(posedge i_clk) begin
        r_feb29_b <= n_feb29;
        r_hour_b  <= n_hour_full[HOUR_W-1:0];
        r_doy_b   <= n_doy;
    end

    always_comb begin
        n_mon = '0;
        for (int m = 0; m < 11; m++) begin
            n_mon = n_mon + MON_W'(r_doy_b > C_MONTH_END[m]);
        end
        n_mday_full = r_doy_b - C_MONTH_START[n_mon];
        n_mday      = n_mday_full[MDAY_W-1:0];
        if (r_feb29_b) begin
            n_mon  = C_MON_FEB;
            n_mday = C_MDAY_FEB29;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hour_c <= r_hour_b;
        r_mday_c <= n_mday;
        r_mon_c  <= n_mon;
    end

    assign o_day.valid = r_vc;
    assign o_day.hour  = r_hour_c;
    assign o_day.mday  = r_mday_c;
    assign o_day.mon   = r_mon_c;

endmodule

// ===== src/epoch_seconds_to_calendar.sv =====
`timescale 1ns / 1ps
// a result for each taken start strobes on o_strobe for one cycle, after it has passed all eight register stages
// throughput: one transfer per cycle while reset is not held, eight register stages, no feedback between items
// busy is high only while reset is held; the receiver cannot stall the pipeline
// reset (synchronous, active low) clears the stage valid bits and drops every item in flight
// multiplier stages: seconds by 60, minutes by 60, hours by four-year block, hours by 24
module epoch_seconds_to_calendar (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ec2c_pkg::EPOCH_W-1:0] i_epoch_seconds,
    output logic                        o_strobe,
    output logic [ec2c_pkg::SEC_W-1:0]  o_second_of_minute,
    output logic [ec2c_pkg::MIN_W-1:0]  o_minute_of_hour,
    output logic [ec2c_pkg::HOUR_W-1:0] o_hour_of_day,
    output logic [ec2c_pkg::MDAY_W-1:0] o_day_of_month,
    output logic [ec2c_pkg::MON_W-1:0]  o_month_index,
    output logic [ec2c_pkg::YEAR_W-1:0] o_full_year
);
    import ec2c_pkg::*;

    logic take;

    // stage 1: seconds times reciprocal of 60
    logic               r_v1;
    logic [EPOCH_W-1:0] r_t1;
    logic [63:0]        r_p1;

    // stage 2: second, minutes times reciprocal of 60
    logic               r_v2;
    logic [26:0]        r_q2;
    logic [SEC_W-1:0]   r_sec2;
    logic [58:0]        r_p2;
    logic [26:0]        n_q1;
    logic [EPOCH_W-1:0] n_q60;

    // stage 3: minute, hours times reciprocal of one block
    logic               r_v3;
    logic [20:0]        r_h3;
    logic [SEC_W-1:0]   r_sec3;
    logic [MIN_W-1:0]   r_min3;
    logic [41:0]        r_p3;
    logic [20:0]        n_h;
    logic [26:0]        n_min_full;

    // stage 4: block count to base year and remainder
    logic               r_v4;
    logic [15:0]        r_rem4;
    logic [YEAR_W-1:0]  r_year4;
    logic [SEC_W-1:0]   r_sec4;
    logic [MIN_W-1:0]   r_min4;
    logic [5:0]         n_quads;
    logic [20:0]        n_rem_full;

    // stage 5: step over up to three years
    logic               r_v5;
    logic               r_leap5;
    logic [YHRS_W-1:0]  r_hrs5;
    logic [YEAR_W-1:0]  r_year5;
    logic [SEC_W-1:0]   r_sec5;
    logic [MIN_W-1:0]   r_min5;
    logic [1:0]         n_yoff;
    logic [15:0]        n_hrs;

    // pass-through alongside the date stages
    logic [SEC_W-1:0]   r_sec_d  [3];
    logic [MIN_W-1:0]   r_min_d  [3];
    logic [YEAR_W-1:0]  r_year_d [3];

    t_day_in  day_in;
    t_day_out day_out;

    assign busy = ~i_rst_n;
    assign take = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        r_t1 <= i_epoch_seconds;
        r_p1 <= 64'(i_epoch_seconds) * 64'(C_RECIP_60);
    end

    // stage 2
    always_comb begin
        n_q1  = r_p1[C_SHIFT_60 +: 27];
        n_q60 = (32'(n_q1) << 6) - (32'(n_q1) << 2);
    end

    always_ff @(posedge i_clk) begin
        r_q2   <= n_q1;
        r_sec2 <= SEC_W'(r_t1 - n_q60);
        r_p2   <= 59'(n_q1) * 59'(C_RECIP_60);
    end

    // stage 3
    always_comb begin
        n_h        = r_p2[C_SHIFT_60 +: 21];
        n_min_full = r_q2 - ((27'(n_h) << 6) - (27'(n_h) << 2));
    end

    always_ff @(posedge i_clk) begin
        r_h3   <= n_h;
        r_sec3 <= r_sec2;
        r_min3 <= n_min_full[MIN_W-1:0];
        r_p3   <= 42'(n_h) * 42'(C_RECIP_QUAD);
    end

    // stage 4
    always_comb begin
        n_quads    = r_p3[C_SHIFT_QUAD +: 6];
        n_rem_full = r_h3 - (21'(n_quads) * C_HOURS_QUAD);
    end

    always_ff @(posedge i_clk) begin
        r_rem4  <= n_rem_full[15:0];
        r_year4 <= C_BASE_YEAR + {4'b0, n_quads, 2'b00};
        r_sec4  <= r_sec3;
        r_min4  <= r_min3;
    end

    // stage 5: a block starts two years before a leap year
    always_comb begin
        if (r_rem4 >= 16'(2 * C_HOURS_COMMON + C_HOURS_LEAP)) begin
            n_yoff = 2'd3;
            n_hrs  = r_rem4 - 16'(2 * C_HOURS_COMMON + C_HOURS_LEAP);
        end else if (r_rem4 >= 16'(2 * C_HOURS_COMMON)) begin
            n_yoff = 2'd2;
            n_hrs  = r_rem4 - 16'(2 * C_HOURS_COMMON);
        end else if (r_rem4 >= C_HOURS_COMMON) begin
            n_yoff = 2'd1;
            n_hrs  = r_rem4 - C_HOURS_COMMON;
        end else begin
            n_yoff = 2'd0;
            n_hrs  = r_rem4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_leap5 <= (n_yoff == 2'd2);
        r_hrs5  <= n_hrs[YHRS_W-1:0];
        r_year5 <= r_year4 + YEAR_W'(n_yoff);
        r_sec5  <= r_sec4;
        r_min5  <= r_min4;
    end

    assign day_in.valid = r_v5;
    assign day_in.leap  = r_leap5;
    assign day_in.hours = r_hrs5;

    ec2c_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_day   (day_in),
        .o_day   (day_out)
    );

    always_ff @(posedge i_clk) begin
        r_sec_d[0]  <= r_sec5;
        r_min_d[0]  <= r_min5;
        r_year_d[0] <= r_year5;
        for (int i = 1; i < 3; i++) begin
            r_sec_d[i]  <= r_sec_d[i-1];
            r_min_d[i]  <= r_min_d[i-1];
            r_year_d[i] <= r_year_d[i-1];
        end
    end

    assign o_strobe           = day_out.valid;
    assign o_second_of_minute = r_sec_d[2];
    assign o_minute_of_hour   = r_min_d[2];
    assign o_hour_of_day      = day_out.hour;
    assign o_day_of_month     = day_out.mday;
    assign o_month_index      = day_out.mon;
    assign o_full_year        = r_year_d[2];

`ifndef SYNTH
    a_strobe_follows_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(take, 8))
        else $error("result strobe without a transfer eight cycles earlier");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_second_of_minute < 6'd60) && (o_minute_of_hour < 6'd60)
                     && (o_hour_of_day < 5'd24))
        else $error("time field out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_month_index <= 4'd11) && (o_day_of_month != 5'd0)
                     && (o_full_year >= C_BASE_YEAR))
        else $error("date field out of range");

    a_feb_leap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_month_index == C_MON_FEB) && (o_day_of_month == C_MDAY_FEB29))
            |-> (o_full_year[1:0] == 2'b00))
        else $error("29 february outside a leap year");

    a_feb_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_month_index == C_MON_FEB)) |-> (o_day_of_month <= C_MDAY_FEB29))
        else $error("february day beyond 29");
`endif

endmodule
